// ----- sv/sstrs_pkg.sv -----
// Shared types, constants and widths of the smoothed scroll tile ring streamer.
// Used by the register file, the controller, the datapath and the top level.
package sstrs_pkg;

  localparam int RING_W        = 32;
  localparam int RING_H        = 32;
  localparam int PLANE_W       = 64;
  localparam int PLANE_H       = 32;
  localparam int WORLD_W_TILES = 120;
  localparam int WORLD_H_TILES = 120;
  localparam int VIEW_W_PX     = 224;
  localparam int VIEW_H_PX     = 192;

  localparam int TGT_MAX_X = (WORLD_W_TILES * 8 - VIEW_W_PX) * 256;
  localparam int TGT_MAX_Y = (WORLD_H_TILES * 8 - VIEW_H_PX) * 256;
  localparam int TGT_MAX   = (TGT_MAX_X > TGT_MAX_Y) ? TGT_MAX_X : TGT_MAX_Y;

  localparam int POS_W  = $clog2(TGT_MAX + 1) + 2;
  localparam int PX_W   = POS_W - 8;
  localparam int TILE_W = POS_W - 11;
  localparam int CRD_W  = TILE_W + 1;

  localparam int TGT_RST_X    = 88 * 256;
  localparam int TGT_RST_Y    = 320 * 256;
  localparam int BASE_RST_COL = 11;
  localparam int BASE_RST_ROW = 40;

  localparam int RING_MAX = (RING_W > RING_H) ? RING_W : RING_H;
  localparam int CNT_W    = $clog2(RING_MAX);
  localparam int RW_B     = $clog2(RING_W);
  localparam int RH_B     = $clog2(RING_H);
  localparam int PW_B     = $clog2(PLANE_W);
  localparam int PH_B     = $clog2(PLANE_H);

  localparam int CX_W = $clog2(WORLD_W_TILES);
  localparam int CY_W = $clog2(WORLD_H_TILES);
  localparam int MULW = CY_W + CX_W + 1;

  localparam int CHUNK_ROWS = 15;
  localparam int RECIP_SH   = 16;
  localparam int RECIP      = (1 << RECIP_SH) / CHUNK_ROWS;
  localparam int QP_W       = CY_W + RECIP_SH;

  localparam int PB_W    = 10;
  localparam int SNAP_W  = 11;
  localparam int STEP_W  = 11;
  localparam int SHIFT_W = 3;
  localparam int SPD_W   = 12;
  localparam int BTN_W   = 5;

  localparam int BTN_LEFT  = 0;
  localparam int BTN_RIGHT = 1;
  localparam int BTN_UP    = 2;
  localparam int BTN_DOWN  = 3;
  localparam int BTN_FAST  = 4;

  localparam int WCOL_W  = 7;
  localparam int WROW_W  = 7;
  localparam int WIDX_W  = 14;
  localparam int CHUNK_W = 3;
  localparam int COFF_W  = 11;
  localparam int PAT_W   = 11;
  localparam int PCOL_W  = 6;
  localparam int PROW_W  = 5;
  localparam int HS_W    = 11;
  localparam int VS_W    = 10;

  localparam int NUM_REGS = 6;
  localparam int CFG_AW   = $clog2(NUM_REGS * 4);
  localparam int CFG_DW   = 32;

  typedef enum logic [CFG_AW-3:0] {
    REG_PATTERN_BASE,
    REG_SNAP,
    REG_MAX_STEP,
    REG_SHIFT,
    REG_SLOW_SPEED,
    REG_FAST_SPEED
  } reg_idx_t;

  typedef struct packed {
    logic [PB_W-1:0]    pattern_base;
    logic [SNAP_W-1:0]  snap;
    logic [STEP_W-1:0]  max_step;
    logic [SHIFT_W-1:0] shift;
    logic [SPD_W-1:0]   slow_speed;
    logic [SPD_W-1:0]   fast_speed;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TARGET,
    ST_FOLLOW,
    ST_DECIDE,
    ST_COL_A,
    ST_COL_B,
    ST_ROW_A,
    ST_ROW_B,
    ST_NONE
  } state_t;

  typedef struct packed {
    logic load_in;
    logic do_target;
    logic do_follow;
    logic do_decide;
    logic cnt_clr;
    logic cnt_inc;
    logic calc_tile;
    logic row_phase;
    logic load_out;
    logic out_tile;
    logic out_last;
  } cmd_t;

  typedef struct packed {
    logic col_move;
    logic row_move;
    logic row_pend;
    logic slot_free;
    logic cnt_last_col;
    logic cnt_last_row;
  } sts_t;

endpackage

// ----- sv/sstrs_regs.sv -----
// Configuration register file on an APB-style port.
// Depends on sstrs_pkg for the register map and the cfg_t bundle.
module sstrs_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [sstrs_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [sstrs_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [sstrs_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                         cfg_pready,
  output sstrs_pkg::cfg_t              cfg
);
  import sstrs_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx        = reg_idx_t'(cfg_paddr[CFG_AW-1:2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pattern_base <= '0;
      cfg_r.snap         <= SNAP_W'(24);
      cfg_r.max_step     <= STEP_W'(1280);
      cfg_r.shift        <= SHIFT_W'(2);
      cfg_r.slow_speed   <= SPD_W'(512);
      cfg_r.fast_speed   <= SPD_W'(768);
    end else if (wr_en) begin
      case (idx)
        REG_PATTERN_BASE: cfg_r.pattern_base <= cfg_pwdata[PB_W-1:0];
        REG_SNAP:         cfg_r.snap         <= cfg_pwdata[SNAP_W-1:0];
        REG_MAX_STEP:     cfg_r.max_step     <= cfg_pwdata[STEP_W-1:0];
        REG_SHIFT:        cfg_r.shift        <= cfg_pwdata[SHIFT_W-1:0];
        REG_SLOW_SPEED:   cfg_r.slow_speed   <= cfg_pwdata[SPD_W-1:0];
        REG_FAST_SPEED:   cfg_r.fast_speed   <= cfg_pwdata[SPD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PATTERN_BASE: cfg_prdata = CFG_DW'(cfg_r.pattern_base);
      REG_SNAP:         cfg_prdata = CFG_DW'(cfg_r.snap);
      REG_MAX_STEP:     cfg_prdata = CFG_DW'(cfg_r.max_step);
      REG_SHIFT:        cfg_prdata = CFG_DW'(cfg_r.shift);
      REG_SLOW_SPEED:   cfg_prdata = CFG_DW'(cfg_r.slow_speed);
      REG_FAST_SPEED:   cfg_prdata = CFG_DW'(cfg_r.fast_speed);
      default:          cfg_prdata = '0;
    endcase
  end

endmodule

// ----- sv/sstrs_ctrl.sv -----
// Frame sequencer: camera update, ring base decision and request emission.
// Depends on sstrs_pkg for state_t, cmd_t and sts_t.
module sstrs_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  sstrs_pkg::sts_t sts,
  output sstrs_pkg::cmd_t cmd
);
  import sstrs_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_TARGET;
        end
      end
      ST_TARGET: begin
        cmd.do_target = 1'b1;
        state_nxt     = ST_FOLLOW;
      end
      ST_FOLLOW: begin
        cmd.do_follow = 1'b1;
        state_nxt     = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd.do_decide = 1'b1;
        cmd.cnt_clr   = 1'b1;
        if (sts.col_move) begin
          state_nxt = ST_COL_A;
        end else if (sts.row_move) begin
          state_nxt = ST_ROW_A;
        end else begin
          state_nxt = ST_NONE;
        end
      end
      ST_COL_A: begin
        cmd.calc_tile = 1'b1;
        state_nxt     = ST_COL_B;
      end
      ST_COL_B: begin
        if (sts.slot_free) begin
          cmd.load_out = 1'b1;
          cmd.out_tile = 1'b1;
          cmd.out_last = sts.cnt_last_col && !sts.row_pend;
          if (sts.cnt_last_col) begin
            cmd.cnt_clr = 1'b1;
            state_nxt   = sts.row_pend ? ST_ROW_A : ST_IDLE;
          end else begin
            cmd.cnt_inc = 1'b1;
            state_nxt   = ST_COL_A;
          end
        end
      end
      ST_ROW_A: begin
        cmd.calc_tile = 1'b1;
        cmd.row_phase = 1'b1;
        state_nxt     = ST_ROW_B;
      end
      ST_ROW_B: begin
        if (sts.slot_free) begin
          cmd.load_out = 1'b1;
          cmd.out_tile = 1'b1;
          cmd.out_last = sts.cnt_last_row;
          if (sts.cnt_last_row) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.cnt_inc = 1'b1;
            state_nxt   = ST_ROW_A;
          end
        end
      end
      ST_NONE: begin
        if (sts.slot_free) begin
          cmd.load_out = 1'b1;
          cmd.out_last = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/sstrs_dp.sv -----
// Datapath: camera target and position, ring base, request fields, output register.
// Depends on sstrs_pkg; driven by sstrs_ctrl through cmd_t, reports through sts_t.
module sstrs_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sstrs_pkg::cfg_t               cfg,
  input  sstrs_pkg::cmd_t               cmd,
  output sstrs_pkg::sts_t               sts,
  input  logic [sstrs_pkg::BTN_W-1:0]   in_buttons,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic                          out_tile_valid,
  output logic [sstrs_pkg::WCOL_W-1:0]  out_world_col,
  output logic [sstrs_pkg::WROW_W-1:0]  out_world_row,
  output logic [sstrs_pkg::WIDX_W-1:0]  out_world_index,
  output logic [sstrs_pkg::CHUNK_W-1:0] out_chunk_number,
  output logic [sstrs_pkg::COFF_W-1:0]  out_chunk_offset,
  output logic [sstrs_pkg::PAT_W-1:0]   out_pattern_index,
  output logic [sstrs_pkg::PCOL_W-1:0]  out_plane_col,
  output logic [sstrs_pkg::PROW_W-1:0]  out_plane_row,
  output logic signed [sstrs_pkg::HS_W-1:0] out_h_scroll,
  output logic [sstrs_pkg::VS_W-1:0]    out_v_scroll,
  output logic                          out_last
);
  import sstrs_pkg::*;

  function automatic logic signed [POS_W-1:0] clamp_tgt(
    input logic signed [POS_W:0] v,
    input logic signed [POS_W:0] hi
  );
    logic signed [POS_W:0] c;
    c = v;
    if (v < 0) c = '0;
    else if (v > hi) c = hi;
    return c[POS_W-1:0];
  endfunction

  function automatic logic signed [POS_W-1:0] follow(
    input logic signed [POS_W-1:0] cur,
    input logic signed [POS_W-1:0] tgt,
    input logic [SNAP_W-1:0]       snap,
    input logic [STEP_W-1:0]       max_step,
    input logic [SHIFT_W-1:0]      shift
  );
    logic signed [POS_W:0] d, s, m, step, sum;
    d    = $signed({tgt[POS_W-1], tgt}) - $signed({cur[POS_W-1], cur});
    s    = $signed({{(POS_W + 1 - SNAP_W){1'b0}}, snap});
    m    = $signed({{(POS_W + 1 - STEP_W){1'b0}}, max_step});
    step = d >>> shift;
    if (step == 0) step = (d > 0) ? (POS_W + 1)'(1) : -(POS_W + 1)'(1);
    if (step > m) step = m;
    else if (step < -m) step = -m;
    sum = $signed({cur[POS_W-1], cur}) + step;
    if (d > -s && d < s) return tgt;
    return sum[POS_W-1:0];
  endfunction

  logic [BTN_W-1:0] btn_r;
  logic signed [POS_W-1:0] tgt_x_r, tgt_y_r, pos_x_r, pos_y_r;
  logic signed [POS_W-1:0] tgt_x_nxt, tgt_y_nxt, pos_x_nxt, pos_y_nxt;
  logic signed [TILE_W-1:0] base_col_r, base_row_r, row0_r;
  logic signed [CRD_W-1:0] line_col_r, line_row_r;
  logic row_pend_r;
  logic [CNT_W-1:0] cnt_r;

  logic [SPD_W-1:0] spd;
  logic signed [POS_W:0] spd_s, dx, dy;
  logic signed [PX_W-1:0] px, py, neg_px;
  logic signed [TILE_W-1:0] tx, ty;
  logic col_fwd, col_back, row_fwd, row_back;

  logic signed [CRD_W-1:0] wx, wy, cnt_s;
  logic [CX_W-1:0] cx;
  logic [CY_W-1:0] cy;
  logic [QP_W-1:0] q_prod;
  logic [MULW-1:0] widx;

  logic [CX_W-1:0]   a_cx_r;
  logic [CY_W-1:0]   a_cy_r, a_q_r;
  logic [MULW-1:0]   a_widx_r;
  logic [PAT_W-1:0]  a_pat_r;
  logic [PCOL_W-1:0] a_pcol_r;
  logic [PROW_W-1:0] a_prow_r;

  logic [CY_W-1:0] rem, q_fix, r_fix;
  logic            fix;
  logic [MULW-1:0] coff;
  logic            out_valid_r;

  // camera target and followed position
  assign spd   = btn_r[BTN_FAST] ? cfg.fast_speed : cfg.slow_speed;
  assign spd_s = $signed({{(POS_W + 1 - SPD_W){1'b0}}, spd});

  always_comb begin
    dx = '0;
    dy = '0;
    if (btn_r[BTN_LEFT] && !btn_r[BTN_RIGHT]) dx = -spd_s;
    if (btn_r[BTN_RIGHT] && !btn_r[BTN_LEFT]) dx = spd_s;
    if (btn_r[BTN_UP] && !btn_r[BTN_DOWN]) dy = -spd_s;
    if (btn_r[BTN_DOWN] && !btn_r[BTN_UP]) dy = spd_s;
    tgt_x_nxt = clamp_tgt($signed({tgt_x_r[POS_W-1], tgt_x_r}) + dx, (POS_W + 1)'(TGT_MAX_X));
    tgt_y_nxt = clamp_tgt($signed({tgt_y_r[POS_W-1], tgt_y_r}) + dy, (POS_W + 1)'(TGT_MAX_Y));
    pos_x_nxt = follow(pos_x_r, tgt_x_r, cfg.snap, cfg.max_step, cfg.shift);
    pos_y_nxt = follow(pos_y_r, tgt_y_r, cfg.snap, cfg.max_step, cfg.shift);
  end

  // pixel and tile position by floor shift
  assign px     = pos_x_r[POS_W-1:8];
  assign py     = pos_y_r[POS_W-1:8];
  assign neg_px = -px;
  assign tx     = pos_x_r[POS_W-1:11];
  assign ty     = pos_y_r[POS_W-1:11];

  assign col_fwd  = tx > base_col_r;
  assign col_back = tx < base_col_r;
  assign row_fwd  = ty > base_row_r;
  assign row_back = ty < base_row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_x_r    <= POS_W'(TGT_RST_X);
      tgt_y_r    <= POS_W'(TGT_RST_Y);
      pos_x_r    <= POS_W'(TGT_RST_X);
      pos_y_r    <= POS_W'(TGT_RST_Y);
      base_col_r <= TILE_W'(BASE_RST_COL);
      base_row_r <= TILE_W'(BASE_RST_ROW);
      row_pend_r <= 1'b0;
      cnt_r      <= '0;
    end else begin
      if (cmd.do_target) begin
        tgt_x_r <= tgt_x_nxt;
        tgt_y_r <= tgt_y_nxt;
      end
      if (cmd.do_follow) begin
        pos_x_r <= pos_x_nxt;
        pos_y_r <= pos_y_nxt;
      end
      if (cmd.do_decide) begin
        row_pend_r <= row_fwd || row_back;
        if (col_fwd) base_col_r <= base_col_r + TILE_W'(1);
        else if (col_back) base_col_r <= base_col_r - TILE_W'(1);
        if (row_fwd) base_row_r <= base_row_r + TILE_W'(1);
        else if (row_back) base_row_r <= base_row_r - TILE_W'(1);
      end
      if (cmd.cnt_clr) cnt_r <= '0;
      else if (cmd.cnt_inc) cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  // button latch; line anchors, kept from the base as it stood before the move
  always_ff @(posedge clk) begin
    if (cmd.load_in) btn_r <= in_buttons;
    if (cmd.do_decide) begin
      row0_r     <= base_row_r;
      line_col_r <= col_fwd ? $signed({base_col_r[TILE_W-1], base_col_r}) + CRD_W'(RING_W)
                            : $signed({base_col_r[TILE_W-1], base_col_r}) - CRD_W'(1);
      line_row_r <= row_fwd ? $signed({base_row_r[TILE_W-1], base_row_r}) + CRD_W'(RING_H)
                            : $signed({base_row_r[TILE_W-1], base_row_r}) - CRD_W'(1);
    end
  end

  // request stage A: world tile, clamps, index products
  assign cnt_s = $signed(CRD_W'(cnt_r));

  always_comb begin
    if (cmd.row_phase) begin
      wx = $signed({base_col_r[TILE_W-1], base_col_r}) + cnt_s;
      wy = line_row_r;
    end else begin
      wx = line_col_r;
      wy = $signed({row0_r[TILE_W-1], row0_r}) + cnt_s;
    end
    if (wx < 0) cx = '0;
    else if (wx > $signed(CRD_W'(WORLD_W_TILES - 1))) cx = CX_W'(WORLD_W_TILES - 1);
    else cx = wx[CX_W-1:0];
    if (wy < 0) cy = '0;
    else if (wy > $signed(CRD_W'(WORLD_H_TILES - 1))) cy = CY_W'(WORLD_H_TILES - 1);
    else cy = wy[CY_W-1:0];
    q_prod = QP_W'(cy) * QP_W'(RECIP);
    widx   = MULW'(cy) * MULW'(WORLD_W_TILES) + MULW'(cx);
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_tile) begin
      a_cx_r   <= cx;
      a_cy_r   <= cy;
      a_q_r    <= q_prod[QP_W-1:RECIP_SH];
      a_widx_r <= widx;
      a_pat_r  <= PAT_W'(cfg.pattern_base) + PAT_W'(wy[RH_B-1:0]) * PAT_W'(RING_W)
                  + PAT_W'(wx[RW_B-1:0]);
      a_pcol_r <= PCOL_W'(wx[PW_B-1:0]);
      a_prow_r <= PROW_W'(wy[PH_B-1:0]);
    end
  end

  // request stage B: chunk remainder with one correction step
  always_comb begin
    rem   = a_cy_r - CY_W'(a_q_r * CY_W'(CHUNK_ROWS));
    fix   = rem >= CY_W'(CHUNK_ROWS);
    q_fix = a_q_r + CY_W'(fix);
    r_fix = fix ? rem - CY_W'(CHUNK_ROWS) : rem;
    coff  = MULW'(r_fix) * MULW'(WORLD_W_TILES) + MULW'(a_cx_r);
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_tile_valid <= cmd.out_tile;
      out_last       <= cmd.out_last;
      out_h_scroll   <= $signed(neg_px[HS_W-1:0]);
      out_v_scroll   <= py[VS_W-1:0];
      if (cmd.out_tile) begin
        out_world_col     <= WCOL_W'(a_cx_r);
        out_world_row     <= WROW_W'(a_cy_r);
        out_world_index   <= WIDX_W'(a_widx_r);
        out_chunk_number  <= CHUNK_W'(q_fix);
        out_chunk_offset  <= COFF_W'(coff);
        out_pattern_index <= a_pat_r;
        out_plane_col     <= a_pcol_r;
        out_plane_row     <= a_prow_r;
      end else begin
        out_world_col     <= '0;
        out_world_row     <= '0;
        out_world_index   <= '0;
        out_chunk_number  <= '0;
        out_chunk_offset  <= '0;
        out_pattern_index <= '0;
        out_plane_col     <= '0;
        out_plane_row     <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;

  assign sts.col_move     = col_fwd || col_back;
  assign sts.row_move     = row_fwd || row_back;
  assign sts.row_pend     = row_pend_r;
  assign sts.slot_free    = !out_valid_r || out_ready;
  assign sts.cnt_last_col = cnt_r == CNT_W'(RING_H - 1);
  assign sts.cnt_last_row = cnt_r == CNT_W'(RING_W - 1);

  a_tgt_range: assert property (@(posedge clk) disable iff (!rst_n)
    tgt_x_r >= 0 && tgt_x_r <= TGT_MAX_X && tgt_y_r >= 0 && tgt_y_r <= TGT_MAX_Y)
    else $error("camera target outside world");

  a_pos_floor: assert property (@(posedge clk) disable iff (!rst_n)
    pos_x_r >= -1 && pos_y_r >= -1)
    else $error("camera position below one sub-pixel under zero");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("output beat overwritten while held");

  a_single_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_decide |=> (base_col_r - $past(base_col_r) <= 1)
                   && ($past(base_col_r) - base_col_r <= 1))
    else $error("ring column base moved more than one tile");

endmodule

// ----- sv/smoothed_scroll_tile_ring_streamer.sv -----
// Smoothed scroll tile ring streamer, top level.
// Depends on sstrs_pkg, sstrs_regs, sstrs_ctrl and sstrs_dp.
//
// Input channel (in_valid/in_ready, in_buttons): one beat per video frame.
// Result channel (out_valid/out_ready, out_*): per frame, RING_H tile-load
// beats for a new ring column, then RING_W beats for a new row, or a single
// scroll-only beat with tile_valid clear; out_last marks the frame's final beat.
// Every beat carries h_scroll and v_scroll of the updated camera.
// Configuration: APB-style port on cfg_*, pready always high. The user must
// see that it is written only while no frame is in flight; the block does not
// enforce this. Sequence: after a frame beat is accepted, the TARGET, FOLLOW and
// DECIDE states update the target, the position and the ring base in turn; each
// request then passes the field stage (COL_A or ROW_A) and then the output
// register (COL_B or ROW_B), which waits while the receiver stalls; the next
// request starts only after that load; the two-stage calculation sets the rate.
// in_ready is high only between frames. A stalled receiver holds the output
// register and the sequencer waits; no beat is dropped.
// Reset (synchronous, rst_n low) restores the register defaults, the camera
// at 88,320 pixels and the ring base at column 11, row 40.
module smoothed_scroll_tile_ring_streamer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sstrs_pkg::BTN_W-1:0]   in_buttons,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_tile_valid,
  output logic [sstrs_pkg::WCOL_W-1:0]  out_world_col,
  output logic [sstrs_pkg::WROW_W-1:0]  out_world_row,
  output logic [sstrs_pkg::WIDX_W-1:0]  out_world_index,
  output logic [sstrs_pkg::CHUNK_W-1:0] out_chunk_number,
  output logic [sstrs_pkg::COFF_W-1:0]  out_chunk_offset,
  output logic [sstrs_pkg::PAT_W-1:0]   out_pattern_index,
  output logic [sstrs_pkg::PCOL_W-1:0]  out_plane_col,
  output logic [sstrs_pkg::PROW_W-1:0]  out_plane_row,
  output logic signed [sstrs_pkg::HS_W-1:0] out_h_scroll,
  output logic [sstrs_pkg::VS_W-1:0]    out_v_scroll,
  output logic                          out_last,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [sstrs_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [sstrs_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [sstrs_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                          cfg_pready
);
  import sstrs_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  sstrs_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  sstrs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sstrs_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .cmd               (cmd),
    .sts               (sts),
    .in_buttons        (in_buttons),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_tile_valid    (out_tile_valid),
    .out_world_col     (out_world_col),
    .out_world_row     (out_world_row),
    .out_world_index   (out_world_index),
    .out_chunk_number  (out_chunk_number),
    .out_chunk_offset  (out_chunk_offset),
    .out_pattern_index (out_pattern_index),
    .out_plane_col     (out_plane_col),
    .out_plane_row     (out_plane_row),
    .out_h_scroll      (out_h_scroll),
    .out_v_scroll      (out_v_scroll),
    .out_last          (out_last)
  );

endmodule

// ----- tb/scroll_stream_checker.sv -----
`timescale 1ns / 1ps
// Checker for the smoothed scroll tile ring streamer: watches the frame, result and
// register ports, predicts each frame's tile-load and scroll beats and compares them.
// Depends on sstrs_pkg for widths, world geometry and register indexes.
module scroll_stream_checker
  import sstrs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [BTN_W-1:0]         in_buttons,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic                     out_tile_valid,
  input  logic [WCOL_W-1:0]        out_world_col,
  input  logic [WROW_W-1:0]        out_world_row,
  input  logic [WIDX_W-1:0]        out_world_index,
  input  logic [CHUNK_W-1:0]       out_chunk_number,
  input  logic [COFF_W-1:0]        out_chunk_offset,
  input  logic [PAT_W-1:0]         out_pattern_index,
  input  logic [PCOL_W-1:0]        out_plane_col,
  input  logic [PROW_W-1:0]        out_plane_row,
  input  logic signed [HS_W-1:0]   out_h_scroll,
  input  logic [VS_W-1:0]          out_v_scroll,
  input  logic                     out_last,
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [CFG_AW-1:0]        cfg_paddr,
  input  logic [CFG_DW-1:0]        cfg_pwdata,
  input  logic                     cfg_pready,
  output int                       fail_count,
  output int                       pending,
  output int                       beat_count,
  output int                       load_count
);

  typedef struct packed {
    logic                   tile_valid;
    logic [WCOL_W-1:0]      world_col;
    logic [WROW_W-1:0]      world_row;
    logic [WIDX_W-1:0]      world_index;
    logic [CHUNK_W-1:0]     chunk_number;
    logic [COFF_W-1:0]      chunk_offset;
    logic [PAT_W-1:0]       pattern_index;
    logic [PCOL_W-1:0]      plane_col;
    logic [PROW_W-1:0]      plane_row;
    logic signed [HS_W-1:0] h_scroll;
    logic [VS_W-1:0]        v_scroll;
    logic                   last;
  } tile_req_t;

  tile_req_t req_q[$];

  int pat_base, snap, max_step, shift, slow_spd, fast_spd;
  int tgt_x, tgt_y, pos_x, pos_y, base_col, base_row;

  function automatic int clip(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int wrap(int v, int m);
    int r;
    r = v % m;
    return (r < 0) ? r + m : r;
  endfunction

  function automatic int chase(int cur, int tgt);
    int d, st;
    d = tgt - cur;
    if (d > -snap && d < snap) return tgt;
    st = d >>> shift;
    if (st == 0) st = (d > 0) ? 1 : -1;
    return cur + clip(st, -max_step, max_step);
  endfunction

  function automatic tile_req_t make_req(int wx, int wy, int px, int py);
    tile_req_t r;
    int cx, cy;
    cx = clip(wx, 0, WORLD_W_TILES - 1);
    cy = clip(wy, 0, WORLD_H_TILES - 1);
    r = '0;
    r.tile_valid    = 1'b1;
    r.world_col     = WCOL_W'(cx);
    r.world_row     = WROW_W'(cy);
    r.world_index   = WIDX_W'(cy * WORLD_W_TILES + cx);
    r.chunk_number  = CHUNK_W'(cy / CHUNK_ROWS);
    r.chunk_offset  = COFF_W'((cy % CHUNK_ROWS) * WORLD_W_TILES + cx);
    r.pattern_index = PAT_W'(pat_base + wrap(wy, RING_H) * RING_W + wrap(wx, RING_W));
    r.plane_col     = PCOL_W'(wrap(wx, PLANE_W));
    r.plane_row     = PROW_W'(wrap(wy, PLANE_H));
    r.h_scroll      = HS_W'(-px);
    r.v_scroll      = VS_W'(py);
    return r;
  endfunction

  task automatic step_camera(input logic [BTN_W-1:0] b);
    tile_req_t frame_q[$];
    tile_req_t r;
    int spd, px, py, tx, ty;
    spd = b[BTN_FAST] ? fast_spd : slow_spd;
    if (b[BTN_LEFT] && !b[BTN_RIGHT]) tgt_x -= spd;
    if (b[BTN_RIGHT] && !b[BTN_LEFT]) tgt_x += spd;
    if (b[BTN_UP] && !b[BTN_DOWN]) tgt_y -= spd;
    if (b[BTN_DOWN] && !b[BTN_UP]) tgt_y += spd;
    tgt_x = clip(tgt_x, 0, TGT_MAX_X);
    tgt_y = clip(tgt_y, 0, TGT_MAX_Y);
    pos_x = chase(pos_x, tgt_x);
    pos_y = chase(pos_y, tgt_y);
    px = pos_x >>> 8;
    py = pos_y >>> 8;
    tx = px >>> 3;
    ty = py >>> 3;

    if (tx > base_col) begin
      for (int i = 0; i < RING_H; i++)
        frame_q.push_back(make_req(base_col + RING_W, base_row + i, px, py));
      base_col++;
    end else if (tx < base_col) begin
      base_col--;
      for (int i = 0; i < RING_H; i++)
        frame_q.push_back(make_req(base_col, base_row + i, px, py));
    end

    if (ty > base_row) begin
      for (int i = 0; i < RING_W; i++)
        frame_q.push_back(make_req(base_col + i, base_row + RING_H, px, py));
      base_row++;
    end else if (ty < base_row) begin
      base_row--;
      for (int i = 0; i < RING_W; i++)
        frame_q.push_back(make_req(base_col + i, base_row, px, py));
    end

    if (frame_q.size() == 0) begin
      r = '0;
      r.h_scroll = HS_W'(-px);
      r.v_scroll = VS_W'(py);
      frame_q.push_back(r);
    end
    frame_q[frame_q.size() - 1].last = 1'b1;
    foreach (frame_q[i]) req_q.push_back(frame_q[i]);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    case (reg_idx_t'(addr[CFG_AW-1:2]))
      REG_PATTERN_BASE: pat_base = int'(data[PB_W-1:0]);
      REG_SNAP:         snap     = int'(data[SNAP_W-1:0]);
      REG_MAX_STEP:     max_step = int'(data[STEP_W-1:0]);
      REG_SHIFT:        shift    = int'(data[SHIFT_W-1:0]);
      REG_SLOW_SPEED:   slow_spd = int'(data[SPD_W-1:0]);
      REG_FAST_SPEED:   fast_spd = int'(data[SPD_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic report(input string msg);
    fail_count++;
    if (fail_count <= 40) $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic signed [31:0] got,
                             input logic signed [31:0] want);
    if (got !== want)
      report($sformatf("beat %0d %s: got %0d, expected %0d", beat_count, name, got, want));
  endtask

  always @(posedge clk) begin : watch
    tile_req_t got, want;
    if (!rst_n) begin
      pat_base   = 0;
      snap       = 24;
      max_step   = 1280;
      shift      = 2;
      slow_spd   = 512;
      fast_spd   = 768;
      tgt_x      = TGT_RST_X;
      tgt_y      = TGT_RST_Y;
      pos_x      = TGT_RST_X;
      pos_y      = TGT_RST_Y;
      base_col   = BASE_RST_COL;
      base_row   = BASE_RST_ROW;
      fail_count = 0;
      beat_count = 0;
      load_count = 0;
      req_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready)
        write_reg(cfg_paddr, cfg_pwdata);
      if (in_valid && in_ready)
        step_camera(in_buttons);
      if (out_valid === 1'b1 && out_ready) begin
        got.tile_valid    = out_tile_valid;
        got.world_col     = out_world_col;
        got.world_row     = out_world_row;
        got.world_index   = out_world_index;
        got.chunk_number  = out_chunk_number;
        got.chunk_offset  = out_chunk_offset;
        got.pattern_index = out_pattern_index;
        got.plane_col     = out_plane_col;
        got.plane_row     = out_plane_row;
        got.h_scroll      = out_h_scroll;
        got.v_scroll      = out_v_scroll;
        got.last          = out_last;
        beat_count++;
        if (got.tile_valid === 1'b1) load_count++;
        if (req_q.size() == 0) begin
          report($sformatf("beat %0d arrived with nothing expected", beat_count));
        end else begin
          want = req_q.pop_front();
          check_field("tile_valid", got.tile_valid, want.tile_valid);
          check_field("world_col", got.world_col, want.world_col);
          check_field("world_row", got.world_row, want.world_row);
          check_field("world_index", got.world_index, want.world_index);
          check_field("chunk_number", got.chunk_number, want.chunk_number);
          check_field("chunk_offset", got.chunk_offset, want.chunk_offset);
          check_field("pattern_index", got.pattern_index, want.pattern_index);
          check_field("plane_col", got.plane_col, want.plane_col);
          check_field("plane_row", got.plane_row, want.plane_row);
          check_field("h_scroll", $signed(got.h_scroll), $signed(want.h_scroll));
          check_field("v_scroll", got.v_scroll, want.v_scroll);
          check_field("last", got.last, want.last);
        end
      end
    end
    pending <= req_q.size();
  end

endmodule

// ----- tb/tb_smoothed_scroll_tile_ring_streamer.sv -----
`timescale 1ns / 1ps
// Top of the smoothed scroll tile ring streamer testbench: clock, reset, frame and
// register stimulus and the verdict. Depends on sstrs_pkg and scroll_stream_checker.
module tb_smoothed_scroll_tile_ring_streamer;
  import sstrs_pkg::*;

  localparam int LIMIT = 1_000_000;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [BTN_W-1:0]       in_buttons = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   out_tile_valid;
  logic [WCOL_W-1:0]      out_world_col;
  logic [WROW_W-1:0]      out_world_row;
  logic [WIDX_W-1:0]      out_world_index;
  logic [CHUNK_W-1:0]     out_chunk_number;
  logic [COFF_W-1:0]      out_chunk_offset;
  logic [PAT_W-1:0]       out_pattern_index;
  logic [PCOL_W-1:0]      out_plane_col;
  logic [PROW_W-1:0]      out_plane_row;
  logic signed [HS_W-1:0] out_h_scroll;
  logic [VS_W-1:0]        out_v_scroll;
  logic                   out_last;
  logic                   cfg_psel = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]      cfg_paddr = '0;
  logic [CFG_DW-1:0]      cfg_pwdata = '0;
  logic [CFG_DW-1:0]      cfg_prdata;
  logic                   cfg_pready;

  int fail_count, pending, beat_count, load_count;
  int cycles = 0;
  int frames = 0;
  int settings = 1;
  bit calm = 1'b0;

  logic [BTN_W-1:0] opening_btns [16] = '{
    5'b00000, 5'b00001, 5'b00010, 5'b00011, 5'b00100, 5'b01000, 5'b01100, 5'b01111,
    5'b10000, 5'b10001, 5'b10010, 5'b10100, 5'b11000, 5'b11111, 5'b00101, 5'b01010
  };

  always #5 clk = ~clk;

  smoothed_scroll_tile_ring_streamer dut (.*);

  scroll_stream_checker checker_i (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("Timeout after %0d cycles with %0d beats outstanding", cycles, pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) out_ready <= calm || ($urandom_range(99) >= 24);

  task automatic apb_write(input reg_idx_t idx, input int value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
  endtask

  task automatic set_config(input int pb, input int sn, input int ms, input int sh,
                            input int sl, input int fa);
    apb_write(REG_PATTERN_BASE, pb);
    apb_write(REG_SNAP, sn);
    apb_write(REG_MAX_STEP, ms);
    apb_write(REG_SHIFT, sh);
    apb_write(REG_SLOW_SPEED, sl);
    apb_write(REG_FAST_SPEED, fa);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    settings++;
  endtask

  task automatic send_frame(input logic [BTN_W-1:0] b);
    if (!calm && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 140)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_buttons <= b;
    do @(posedge clk); while (!in_ready);
    frames++;
  endtask

  // hold one button pattern, with the given percentage of random frames mixed in
  task automatic hold(input logic [BTN_W-1:0] b, input int len, input int noise);
    repeat (len)
      send_frame(($urandom_range(99) < noise) ? BTN_W'($urandom_range(31)) : b);
  endtask

  task automatic random_runs(input int n);
    int left, len;
    left = n;
    while (left > 0) begin
      len = $urandom_range(1, 12);
      if (len > left) len = left;
      if ($urandom_range(9) < 7) hold(BTN_W'($urandom_range(31)), len, 0);
      else hold('0, len, 100);
      left -= len;
    end
  endtask

  // stop sending and let every outstanding beat come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (opening_btns[i]) send_frame(opening_btns[i]);
    drain();

    set_config(1023, 0, 2047, 0, 4095, 4095);
    hold('0, 3, 0);
    hold(5'b10101, 40, 10);
    hold(5'b11010, 95, 10);
    drain();

    set_config(0, 2047, 1, 7, 0, 0);
    random_runs(15);
    drain();

    repeat (2) begin
      set_config($urandom_range(1023), $urandom_range(2047), $urandom_range(1, 2047),
                 $urandom_range(7), $urandom_range(4095), $urandom_range(4095));
      random_runs(15);
      drain();
    end

    calm <= 1'b1;
    set_config(512, 24, 1280, 2, 512, 768);
    random_runs(15);
    drain();
    calm <= 1'b0;

    $display("Ran %0d frames under %0d register settings, corner sweeps included",
             frames, settings);
    $display("Checked %0d result beats, %0d of them tile loads", beat_count, load_count);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
